// File: sv/btadc_pkg.sv
// ----------------------------------------------------------------------------
// btadc_pkg
// Shared constants, command codes and the queue entry of the row scoring scan.
// ----------------------------------------------------------------------------
`default_nettype none

package btadc_pkg;

	localparam int MAX_CODE_BYTES = 256;
	localparam int BYTE_VALUES    = 256;
	localparam int POS_W          = $clog2(MAX_CODE_BYTES);
	localparam int BYTE_W         = $clog2(BYTE_VALUES);
	localparam int TABLE_DEPTH    = MAX_CODE_BYTES * BYTE_VALUES;
	localparam int ADDR_W         = POS_W + BYTE_W;

	localparam int VALUE_W  = 32;
	localparam int SUM_W    = VALUE_W + POS_W;
	localparam int NORM_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int LO_W     = 32;
	localparam int HI_W     = SUM_W - LO_W;
	localparam int MID_W    = HI_W + NORM_W + 1;
	localparam int SCORE_W  = 48;
	localparam int ROW_W    = 24;
	localparam int CB_W     = 9;
	localparam int EXT_W    = SUM_W - VALUE_W;
	localparam int PAD_W    = SCORE_W - SUM_W;

	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	// register index is the word address bit
	localparam logic REG_CODE_BYTES = 1'b0;
	localparam logic REG_USE_NORMS  = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_CODE    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [NORM_W-1:0]  norm;
		logic [ROW_W-1:0]   row_id;
		logic               first;
		logic               last;
	} entry_t;

endpackage

`default_nettype wire

// File: sv/byte_table_adc_row_scoring_top.sv
// Path: a row's last code byte goes via RAM read, queue, s2 to s5 and output reg.
// Throughput: one input word per cycle while the queue has room; one RAM port
// access per word; the back end takes one queued byte per cycle unless stalled.
// Reset: arst_n clears control state, row position, row number and registers
// (code_bytes 1, use_norms 0); the score table is undefined until loaded.
// ----------------------------------------------------------------------------
// byte_table_adc_row_scoring_top
// Asymmetric-distance row scoring scan with a loadable per-query score table.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_table_adc_row_scoring_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// table_position, table_code, table_value, code, norm
	input  wire logic [btadc_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd
	input  wire logic [btadc_pkg::CMD_W-1:0]          s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// score, row_id
	output logic      [btadc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// saturated
	output logic      [0:0]                           m_tuser,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [btadc_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [btadc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [btadc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready
);

	logic [btadc_pkg::CB_W-1:0]    code_bytes_q;
	logic                          use_norms_q;
	logic                          cfg_write;

	logic                          ram_we;
	logic                          ram_re;
	logic [btadc_pkg::ADDR_W-1:0]  ram_addr;
	logic [btadc_pkg::VALUE_W-1:0] ram_wdata;
	logic [btadc_pkg::VALUE_W-1:0] ram_rdata;

	logic                          push;
	btadc_pkg::entry_t             push_entry;
	logic                          pop;
	btadc_pkg::entry_t             head;
	logic [btadc_pkg::QLVL_W-1:0]  level;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bytes_q <= btadc_pkg::CB_W'(1);
			use_norms_q  <= 1'b0;
		end else if (cfg_write) begin
			if (paddr[2] == btadc_pkg::REG_CODE_BYTES) begin
				code_bytes_q <= pwdata[btadc_pkg::CB_W-1:0];
			end else begin
				use_norms_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == btadc_pkg::REG_USE_NORMS)
		? {{(btadc_pkg::APB_DATA_W-1){1'b0}}, use_norms_q}
		: {{(btadc_pkg::APB_DATA_W-btadc_pkg::CB_W){1'b0}}, code_bytes_q};

	btadc_ram #(
		.WIDTH(btadc_pkg::VALUE_W),
		.DEPTH(btadc_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	btadc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.code_bytes(code_bytes_q),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.q_level   (level),
		.push      (push),
		.push_entry(push_entry)
	);

	btadc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.level     (level)
	);

	btadc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.level    (level),
		.pop      (pop),
		.use_norms(use_norms_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: sv/btadc_ram.sv
// ----------------------------------------------------------------------------
// btadc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btadc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/btadc_front.sv
// ----------------------------------------------------------------------------
// btadc_front
// Accepts input words, writes table entries, tracks the byte position and row
// number, issues the table read and pushes each code byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module btadc_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [btadc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic [btadc_pkg::CMD_W-1:0]          s_tuser,
	input  wire logic [btadc_pkg::CB_W-1:0]           code_bytes,
	output logic                                      ram_we,
	output logic                                      ram_re,
	output logic      [btadc_pkg::ADDR_W-1:0]         ram_addr,
	output logic      [btadc_pkg::VALUE_W-1:0]        ram_wdata,
	input  wire logic [btadc_pkg::VALUE_W-1:0]        ram_rdata,
	input  wire logic [btadc_pkg::QLVL_W-1:0]         q_level,
	output logic                                      push,
	output btadc_pkg::entry_t                         push_entry
);

	logic [btadc_pkg::BYTE_W-1:0]  table_position;
	logic [btadc_pkg::BYTE_W-1:0]  table_code;
	logic [btadc_pkg::VALUE_W-1:0] table_value;
	logic [btadc_pkg::BYTE_W-1:0]  code;
	logic [btadc_pkg::NORM_W-1:0]  norm;
	btadc_pkg::cmd_t               cmd;

	logic                          accept;
	logic                          is_code;
	logic [btadc_pkg::POS_W-1:0]   last_pos;
	logic                          last_byte;

	logic [btadc_pkg::POS_W-1:0]   byte_pos_q;
	logic [btadc_pkg::ROW_W-1:0]   row_q;
	logic                          valid_s1;
	logic [btadc_pkg::NORM_W-1:0]  norm_s1;
	logic [btadc_pkg::ROW_W-1:0]   row_s1;
	logic                          first_s1;
	logic                          last_s1;

	assign table_position = s_tdata[7:0];
	assign table_code     = s_tdata[15:8];
	assign table_value    = s_tdata[47:16];
	assign code           = s_tdata[55:48];
	assign norm           = s_tdata[87:56];
	assign cmd            = btadc_pkg::cmd_t'(s_tuser);

	// leave room in the queue for the byte still in flight
	assign s_tready = ((btadc_pkg::QLVL_W+1)'(q_level) + (btadc_pkg::QLVL_W+1)'(valid_s1))
		< (btadc_pkg::QLVL_W+1)'(btadc_pkg::QUEUE_DEPTH);
	assign accept  = s_tvalid && s_tready;
	assign is_code = (cmd == btadc_pkg::CMD_CODE);

	// zero counts as one, anything above the maximum as the maximum
	always_comb begin
		if (code_bytes[btadc_pkg::CB_W-1]) begin
			last_pos = {btadc_pkg::POS_W{1'b1}};
		end else if (code_bytes[btadc_pkg::POS_W-1:0] == '0) begin
			last_pos = '0;
		end else begin
			last_pos = code_bytes[btadc_pkg::POS_W-1:0] - btadc_pkg::POS_W'(1);
		end
	end
	assign last_byte = (byte_pos_q >= last_pos);

	assign ram_we    = accept && (cmd == btadc_pkg::CMD_LOAD);
	assign ram_re    = accept && is_code;
	assign ram_wdata = table_value;
	assign ram_addr  = (cmd == btadc_pkg::CMD_LOAD) ? {table_position, table_code}
		: {byte_pos_q, code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && is_code;
			if (accept) begin
				case (cmd)
					btadc_pkg::CMD_CODE: begin
						if (last_byte) begin
							byte_pos_q <= '0;
							row_q      <= row_q + btadc_pkg::ROW_W'(1);
						end else begin
							byte_pos_q <= byte_pos_q + btadc_pkg::POS_W'(1);
						end
					end
					btadc_pkg::CMD_RESTART: begin
						byte_pos_q <= '0;
						row_q      <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_code) begin
			norm_s1  <= norm;
			row_s1   <= row_q;
			first_s1 <= (byte_pos_q == '0);
			last_s1  <= last_byte;
		end
	end

	// table data arrives in the cycle after the read
	assign push              = valid_s1;
	assign push_entry.value  = ram_rdata;
	assign push_entry.norm   = norm_s1;
	assign push_entry.row_id = row_s1;
	assign push_entry.first  = first_s1;
	assign push_entry.last   = last_s1;

endmodule

`default_nettype wire

// File: sv/btadc_queue.sv
// ----------------------------------------------------------------------------
// btadc_queue
// Short queue of looked-up code bytes between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module btadc_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire btadc_pkg::entry_t             push_entry,
	input  wire logic                          pop,
	output btadc_pkg::entry_t                  head,
	output logic      [btadc_pkg::QLVL_W-1:0]  level
);

	btadc_pkg::entry_t             mem_q [btadc_pkg::QUEUE_DEPTH];
	logic [btadc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [btadc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [btadc_pkg::QLVL_W-1:0]  level_q;

	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + btadc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + btadc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + btadc_pkg::QLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - btadc_pkg::QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// File: sv/btadc_back.sv
// ----------------------------------------------------------------------------
// btadc_back
// Accumulates row sums, scales finished rows by their norm if use_norms is set,
// floors, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btadc_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire btadc_pkg::entry_t                    head,
	input  wire logic [btadc_pkg::QLVL_W-1:0]         level,
	output logic                                      pop,
	input  wire logic                                 use_norms,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [btadc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic      [0:0]                           m_tuser
);

	logic                                                   en;
	logic [btadc_pkg::SUM_W-1:0]                            value_ext;
	logic [btadc_pkg::SUM_W-1:0]                            sum;
	logic [btadc_pkg::SUM_W-1:0]                            acc_q;

	logic                                                   valid_s2;
	logic [btadc_pkg::SUM_W-1:0]                            sum_s2;
	logic [btadc_pkg::NORM_W-1:0]                           norm_s2;
	logic [btadc_pkg::ROW_W-1:0]                            row_s2;

	logic                                                   valid_s3;
	logic                                                   neg_s3;
	logic [btadc_pkg::SUM_W-1:0]                            mag_s3;
	logic [btadc_pkg::NORM_W-1:0]                           norm_s3;
	logic [btadc_pkg::ROW_W-1:0]                            row_s3;

	logic                                                   valid_s4;
	logic                                                   neg_s4;
	logic                                                   scale_s4;
	logic [btadc_pkg::SUM_W-1:0]                            mag_s4;
	logic [btadc_pkg::LO_W+btadc_pkg::NORM_W-1:0]           lo_s4;
	logic [btadc_pkg::HI_W+btadc_pkg::NORM_W-1:0]           hi_s4;
	logic [btadc_pkg::ROW_W-1:0]                            row_s4;

	logic [btadc_pkg::MID_W-1:0]                            mid;
	logic [btadc_pkg::SCORE_W-1:0]                          q_next;
	logic                                                   big_next;
	logic                                                   rem_next;

	logic                                                   valid_s5;
	logic                                                   neg_s5;
	logic                                                   big_s5;
	logic                                                   rem_s5;
	logic [btadc_pkg::SCORE_W-1:0]                          q_s5;
	logic [btadc_pkg::ROW_W-1:0]                            row_s5;

	logic [btadc_pkg::SCORE_W-1:0]                          score_next;
	logic                                                   sat_next;

	logic                                                   out_valid_q;
	logic [btadc_pkg::SCORE_W-1:0]                          score_q;
	logic [btadc_pkg::ROW_W-1:0]                            row_q;
	logic                                                   sat_q;

	assign en  = !out_valid_q || m_tready;
	assign pop = en && (level != '0);

	// the first byte of a row starts a fresh sum
	assign value_ext = {{btadc_pkg::EXT_W{head.value[btadc_pkg::VALUE_W-1]}}, head.value};
	assign sum       = head.first ? value_ext : acc_q + value_ext;

	// product of 40-bit magnitude and 32-bit norm, from two partial products
	assign mid = {1'b0, hi_s4}
		+ btadc_pkg::MID_W'(lo_s4[btadc_pkg::LO_W+btadc_pkg::NORM_W-1:btadc_pkg::LO_W]);

	always_comb begin
		if (scale_s4) begin
			big_next = |mid[btadc_pkg::MID_W-1:btadc_pkg::NORM_W];
			q_next   = {mid[btadc_pkg::NORM_W-1:0],
				lo_s4[btadc_pkg::LO_W-1:btadc_pkg::FRAC_W]};
			rem_next = |lo_s4[btadc_pkg::FRAC_W-1:0];
		end else begin
			big_next = 1'b0;
			q_next   = {{btadc_pkg::PAD_W{1'b0}}, mag_s4};
			rem_next = 1'b0;
		end
	end

	// floor of a negative value rounds its magnitude up: -(q+1) is ~q
	always_comb begin
		if (!neg_s5) begin
			sat_next   = big_s5 || q_s5[btadc_pkg::SCORE_W-1];
			score_next = sat_next ? btadc_pkg::SCORE_MAX : q_s5;
		end else begin
			sat_next = big_s5 || (q_s5[btadc_pkg::SCORE_W-1]
				&& ((|q_s5[btadc_pkg::SCORE_W-2:0]) || rem_s5));
			if (sat_next) begin
				score_next = btadc_pkg::SCORE_MIN;
			end else if (rem_s5) begin
				score_next = ~q_s5;
			end else begin
				score_next = -q_s5;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= sum;
			end
			if (en) begin
				valid_s2    <= pop && head.last;
				valid_s3    <= valid_s2;
				valid_s4    <= valid_s3;
				valid_s5    <= valid_s4;
				out_valid_q <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2   <= sum;
			norm_s2  <= head.norm;
			row_s2   <= head.row_id;

			neg_s3   <= sum_s2[btadc_pkg::SUM_W-1];
			mag_s3   <= sum_s2[btadc_pkg::SUM_W-1] ? -sum_s2 : sum_s2;
			norm_s3  <= norm_s2;
			row_s3   <= row_s2;

			neg_s4   <= neg_s3;
			scale_s4 <= use_norms;
			mag_s4   <= mag_s3;
			lo_s4    <= {{btadc_pkg::NORM_W{1'b0}}, mag_s3[btadc_pkg::LO_W-1:0]}
				* {{btadc_pkg::LO_W{1'b0}}, norm_s3};
			hi_s4    <= {{btadc_pkg::NORM_W{1'b0}},
				mag_s3[btadc_pkg::SUM_W-1:btadc_pkg::LO_W]}
				* {{btadc_pkg::HI_W{1'b0}}, norm_s3};
			row_s4   <= row_s3;

			neg_s5   <= neg_s4;
			big_s5   <= big_next;
			rem_s5   <= rem_next;
			q_s5     <= q_next;
			row_s5   <= row_s4;

			if (valid_s5) begin
				score_q <= score_next;
				row_q   <= row_s5;
				sat_q   <= sat_next;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {row_q, score_q};
	assign m_tuser[0] = sat_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_byte_table_adc_row_scoring_top.sv
// ----------------------------------------------------------------------------
// tb_byte_table_adc_row_scoring_top
// Self-checking bench for the table-lookup row scorer. Loads table entries,
// streams code bytes under several row lengths and norm settings, and checks
// every row score, row number and clip flag against a scoring model kept
// inside the bench. Both stream sides idle at random, and one long output
// stall backs the scan up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_table_adc_row_scoring_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [btadc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 250;
	localparam int MAX_REPORTS  = 10;

	localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [31:0] NORM_ONE = 32'h0001_0000;
	localparam logic [31:0] NORM_MAX = 32'hffff_ffff;

	localparam logic signed [127:0] SCORE_HI = 128'sh7fff_ffff_ffff;
	localparam logic signed [127:0] SCORE_LO = -128'sh8000_0000_0000;

	typedef struct {
		logic [btadc_pkg::SCORE_W-1:0] score;
		logic [btadc_pkg::ROW_W-1:0]   row_id;
		logic                          saturated;
	} row_score_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// table_position, table_code, table_value, code, norm
	logic [btadc_pkg::IN_DATA_W-1:0]  s_tdata;
	// cmd
	logic [btadc_pkg::CMD_W-1:0]      s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	// score, row_id
	logic [btadc_pkg::OUT_DATA_W-1:0] m_tdata;
	// saturated
	logic [0:0]                       m_tuser;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [btadc_pkg::APB_ADDR_W-1:0] paddr;
	logic [btadc_pkg::APB_DATA_W-1:0] pwdata;
	logic [btadc_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;

	byte_table_adc_row_scoring_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// scoring model state
	logic [btadc_pkg::VALUE_W-1:0] score_tbl [btadc_pkg::TABLE_DEPTH];
	bit                            loaded [btadc_pkg::TABLE_DEPTH];
	logic signed [63:0]            row_acc;
	int unsigned                   row_pos;
	logic [btadc_pkg::ROW_W-1:0]   next_row;
	logic [btadc_pkg::CB_W-1:0]    cfg_bytes;
	bit                            cfg_norms;
	row_score_t                    expected_rows[$];

	int mismatches;
	int rows_seen;
	int rows_sat;
	int loads_sent;
	int bytes_sent;
	int cycles;
	int holds_asked;
	int holds_granted;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_fail(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch: %s expected %h got %h", what, want, got);
	endfunction

	function automatic int unsigned row_length();
		if (cfg_bytes == 0)
			return 1;
		if (cfg_bytes > btadc_pkg::MAX_CODE_BYTES)
			return btadc_pkg::MAX_CODE_BYTES;
		return cfg_bytes;
	endfunction

	// exact product, floor shift back to Q16.16, clip to 48 bits
	function automatic row_score_t scale_and_clip(input logic signed [63:0] sum,
		input logic [31:0] nrm, input bit scale);
		logic signed [127:0] wide;
		row_score_t r;
		wide = sum;
		if (scale)
			wide = (wide * $signed({96'd0, nrm})) >>> btadc_pkg::FRAC_W;
		r.row_id = '0;
		r.saturated = 1'b0;
		if (wide > SCORE_HI) begin
			r.score = btadc_pkg::SCORE_MAX;
			r.saturated = 1'b1;
		end else if (wide < SCORE_LO) begin
			r.score = btadc_pkg::SCORE_MIN;
			r.saturated = 1'b1;
		end else begin
			r.score = wide[btadc_pkg::SCORE_W-1:0];
		end
		return r;
	endfunction

	task automatic track_word(input logic [btadc_pkg::CMD_W-1:0] cmd,
		input logic [7:0] tpos, input logic [7:0] tcode, input logic [31:0] tval,
		input logic [7:0] cbyte, input logic [31:0] nrm);
		logic [btadc_pkg::VALUE_W-1:0] entry;
		row_score_t r;
		case (cmd)
			btadc_pkg::CMD_LOAD: begin
				score_tbl[{tpos, tcode}] = tval;
				loaded[{tpos, tcode}] = 1'b1;
				loads_sent++;
			end
			btadc_pkg::CMD_RESTART: begin
				row_acc = '0;
				row_pos = 0;
				next_row = '0;
			end
			btadc_pkg::CMD_CODE: begin
				bytes_sent++;
				entry = score_tbl[{row_pos[7:0], cbyte}];
				row_acc += {{32{entry[btadc_pkg::VALUE_W-1]}}, entry};
				if (row_pos + 1 >= row_length()) begin
					r = scale_and_clip(row_acc, nrm, cfg_norms);
					r.row_id = next_row;
					expected_rows.push_back(r);
					next_row++;
					row_acc = '0;
					row_pos = 0;
				end else begin
					row_pos++;
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(input logic [btadc_pkg::CMD_W-1:0] cmd,
		input logic [7:0] tpos, input logic [7:0] tcode, input logic [31:0] tval,
		input logic [7:0] cbyte, input logic [31:0] nrm);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {nrm, cbyte, tval, tcode, tpos};
		do @(posedge clk); while (!s_tready);
		track_word(cmd, tpos, tcode, tval, cbyte, nrm);
	endtask

	task automatic send_load(input logic [7:0] tpos, input logic [7:0] tcode,
		input logic [31:0] tval);
		send_word(btadc_pkg::CMD_LOAD, tpos, tcode, tval, 8'($urandom), $urandom);
	endtask

	task automatic send_code(input logic [7:0] cbyte, input logic [31:0] nrm);
		send_word(btadc_pkg::CMD_CODE, 8'($urandom), 8'($urandom), $urandom, cbyte, nrm);
	endtask

	task automatic send_restart();
		send_word(btadc_pkg::CMD_RESTART, 8'($urandom), 8'($urandom), $urandom,
			8'($urandom), $urandom);
	endtask

	task automatic send_unused();
		send_word(CMD_UNUSED, 8'($urandom), 8'($urandom), $urandom, 8'($urandom), $urandom);
	endtask

	// wait out pending rows, then the pipeline behind a byte that ends no row
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		logic [31:0] back;
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == btadc_pkg::REG_CODE_BYTES) begin
			cfg_bytes = data[btadc_pkg::CB_W-1:0];
			want = {23'd0, data[btadc_pkg::CB_W-1:0]};
		end else begin
			cfg_norms = data[0];
			want = {31'd0, data[0]};
		end
		// read it back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		back = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (back !== want)
			note_fail("register readback", want, back);
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned nbytes, input bit norms);
		drain();
		write_reg(btadc_pkg::REG_CODE_BYTES, 32'(nbytes));
		write_reg(btadc_pkg::REG_USE_NORMS, 32'(norms));
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_norm();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return NORM_MAX;
			2: return NORM_ONE;
			3, 4: return $urandom_range(0, 32'h0002_ffff);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_table_and_raw_sums();
		send_load(8'd0, 8'd0, VAL_MAX);
		send_load(8'd0, 8'd255, VAL_MIN);
		send_load(8'd1, 8'd0, VAL_MAX);
		send_load(8'd1, 8'd255, VAL_MIN);
		send_load(8'd0, 8'd1, 32'hffff_fffd);
		send_load(8'd255, 8'haa, $urandom);
		send_code(8'd0, NORM_MAX);
		send_code(8'd255, NORM_MAX);
		send_unused();
		// restart brings the row number back to zero
		send_restart();
		send_code(8'd1, $urandom);
	endtask

	task automatic test_norm_scaling();
		configure(2, 1'b1);
		send_code(8'd0, $urandom);
		send_code(8'd0, NORM_MAX);
		send_code(8'd255, $urandom);
		send_code(8'd255, NORM_MAX);
		configure(1, 1'b1);
		// small negative sum times tiny norm floors to -1 lsb
		send_code(8'd1, 32'd1);
		send_code(8'd0, 32'd0);
		send_code(8'd0, NORM_ONE);
	endtask

	task automatic test_row_length_corners();
		configure(2, 1'b1);
		send_code(8'd0, $urandom);
		// shorter row length while a row is open: next byte closes it
		configure(1, 1'b1);
		send_code(8'd0, NORM_ONE);
		configure(0, 1'b0);
		send_code(8'd255, $urandom);
		send_code(8'd0, $urandom);
	endtask

	task automatic test_backpressure();
		configure(1, 1'b0);
		send_restart();
		holds_asked++;
		repeat (48)
			send_code($urandom_range(0, 1) ? 8'd0 : 8'd255, $urandom);
		drain();
	endtask

	task automatic test_random_phases();
		int unsigned phase_bytes [8] = '{1, 3, 0, 8, 2, 256, 511, 5};
		bit phase_norms [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		int phase_words [8] = '{120, 150, 100, 140, 140, 500, 290, 120};
		logic [7:0] palette [3];
		logic [7:0] p;
		logic [7:0] c;
		int sent;
		int r;
		foreach (palette[i])
			palette[i] = 8'($urandom);
		for (int ph = 0; ph < 8; ph++) begin
			configure(phase_bytes[ph], phase_norms[ph]);
			sent = 0;
			while (sent < phase_words[ph]) begin
				r = $urandom_range(0, 999);
				if (r < 70) begin
					send_load(8'($urandom), 8'($urandom), pick_value());
					sent++;
				end else if (r < 90) begin
					send_unused();
				end else if (r < 93) begin
					send_restart();
					sent++;
				end else begin
					// mostly a few byte values so loaded entries get reused
					p = row_pos[7:0];
					c = (r < 170) ? 8'($urandom) : palette[$urandom_range(0, 2)];
					if (!loaded[{p, c}]) begin
						send_load(p, c, pick_value());
						sent++;
					end
					send_code(c, pick_norm());
					sent++;
				end
			end
		end
		drain();
	endtask

	// output side: random stalls, plus one long hold on request
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_granted != holds_asked) begin
				holds_granted = holds_asked;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	// stretches with no idling on either side
	initial begin
		quiet <= 1'b0;
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			quiet <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		row_score_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rows.size() == 0) begin
				note_fail("row with none pending", '0, m_tdata[btadc_pkg::SCORE_W-1:0]);
			end else begin
				want = expected_rows.pop_front();
				rows_seen++;
				if (want.saturated)
					rows_sat++;
				if (m_tdata[btadc_pkg::SCORE_W-1:0] !== want.score)
					note_fail("score", want.score, m_tdata[btadc_pkg::SCORE_W-1:0]);
				if (m_tdata[btadc_pkg::OUT_DATA_W-1:btadc_pkg::SCORE_W] !== want.row_id)
					note_fail("row_id", want.row_id,
						m_tdata[btadc_pkg::OUT_DATA_W-1:btadc_pkg::SCORE_W]);
				if (m_tuser[0] !== want.saturated)
					note_fail("saturated", want.saturated, m_tuser[0]);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles <= LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d rows pending", cycles, expected_rows.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		row_acc = '0;
		row_pos = 0;
		next_row = '0;
		cfg_bytes = 9'd1;
		cfg_norms = 1'b0;
		mismatches = 0;
		rows_seen = 0;
		rows_sat = 0;
		loads_sent = 0;
		bytes_sent = 0;
		holds_asked = 0;
		holds_granted = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_and_raw_sums();
		test_norm_scaling();
		test_row_length_corners();
		test_backpressure();
		test_random_phases();

		if (expected_rows.size() != 0)
			note_fail("rows never returned", expected_rows.size(), '0);
		$display("ran %0d table loads and %0d code bytes, checked %0d rows (%0d clipped)",
			loads_sent, bytes_sent, rows_seen, rows_sat);
		$display("row lengths 0 to 511, raw and norm-scaled sums, one long output stall");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
